>>> hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros
// shared concurrent assertion macros for the keyed hash checker
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off during reset
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication, always on
`define ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

>>> hdl/shk_pkg.sv
// ----------------------------------------------------------------------------
// shk_pkg
// types, constants and round function shared by the keyed hash block
// ----------------------------------------------------------------------------
package shk_pkg;

  localparam logic [63:0] SIP_C0 = 64'h736f6d6570736575;
  localparam logic [63:0] SIP_C1 = 64'h646f72616e646f6d;
  localparam logic [63:0] SIP_C2 = 64'h6c7967656e657261;
  localparam logic [63:0] SIP_C3 = 64'h7465646279746573;
  localparam logic [63:0] FIN_XOR = 64'h00000000000000ff;

  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [3:0] RND_NONE = 4'd0;
  localparam logic [3:0] RND_LAST = 4'd1;
  localparam logic [3:0] RST_C_ROUNDS = 4'd2;
  localparam logic [3:0] RST_D_ROUNDS = 4'd4;
  localparam logic [3:0] WORD_BYTES = 4'd8;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KEY_LOW  = 2'd0,
    CFG_KEY_HIGH = 2'd1,
    CFG_C_ROUNDS = 2'd2,
    CFG_D_ROUNDS = 2'd3
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ABSORB,
    ST_FIN_LOAD,
    ST_FIN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [63:0] v0;
    logic [63:0] v1;
    logic [63:0] v2;
    logic [63:0] v3;
  } lanes_t;

  typedef struct packed {
    logic accept;
    logic fin_load;
    logic inject;
    logic do_round;
    logic xor_m;
    logic xor_ff;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic       full;
    logic [3:0] c_rounds;
    logic [3:0] d_rounds;
    logic       out_free;
  } sts_t;

  function automatic lanes_t sip_round(lanes_t l);
    logic [63:0] a0, a1, a2, a3;
    lanes_t      r;
    a0 = l.v0 + l.v1;
    a2 = l.v2 + l.v3;
    a1 = {l.v1[50:0], l.v1[63:51]} ^ a0;
    a3 = {l.v3[47:0], l.v3[63:48]} ^ a2;
    a0 = {a0[31:0], a0[63:32]};
    a2 = a2 + a1;
    a0 = a0 + a3;
    a1 = {a1[46:0], a1[63:47]} ^ a2;
    a3 = {a3[42:0], a3[63:43]} ^ a0;
    a2 = {a2[31:0], a2[63:32]};
    r.v0 = a0;
    r.v1 = a1;
    r.v2 = a2;
    r.v3 = a3;
    return r;
  endfunction

endpackage

>>> hdl/shk_if.sv
// ----------------------------------------------------------------------------
// shk_if
// valid/ready channels for message words and digests
// ----------------------------------------------------------------------------
interface shk_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] msg_bytes;
  logic [3:0]  byte_count;
  logic        end_of_message;

  modport source (output valid, msg_bytes, byte_count, end_of_message, input ready);
  modport sink (input valid, msg_bytes, byte_count, end_of_message, output ready);
endinterface

interface shk_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] digest;

  modport source (output valid, digest, input ready);
  modport sink (input valid, digest, output ready);
endinterface

>>> hdl/shk_ctrl.sv
// ----------------------------------------------------------------------------
// shk_ctrl
// sequencer for word absorption, finalization rounds and digest hand-off
// ----------------------------------------------------------------------------
module shk_ctrl
  import shk_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic in_end,
  input  sts_t sts,
  output logic in_ready,
  output cmd_t cmd
);

  state_t     state_r, state_nxt;
  logic [3:0] cnt_r, cnt_nxt;
  logic       end_r, end_nxt;
  logic       fin_r, fin_nxt;
  logic       acc;
  logic       c_zero, d_zero, last;

  assign acc    = in_valid && (state_r == ST_IDLE);
  assign c_zero = (sts.c_rounds == RND_NONE);
  assign d_zero = (sts.d_rounds == RND_NONE);
  assign last   = (cnt_r <= RND_LAST);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= RND_NONE;
      end_r   <= 1'b0;
      fin_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      end_r   <= end_nxt;
      fin_r   <= fin_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    end_nxt   = end_r;
    fin_nxt   = fin_r;
    case (state_r)
      ST_IDLE: begin
        if (acc) begin
          end_nxt = in_end;
          fin_nxt = 1'b0;
          if (sts.full && !c_zero) begin
            state_nxt = ST_ABSORB;
            cnt_nxt   = sts.c_rounds;
          end else if (in_end) begin
            state_nxt = ST_FIN_LOAD;
          end
        end
      end
      ST_ABSORB: begin
        if (last) begin
          if (fin_r) begin
            state_nxt = d_zero ? ST_DONE : ST_FIN;
            cnt_nxt   = sts.d_rounds;
          end else begin
            state_nxt = end_r ? ST_FIN_LOAD : ST_IDLE;
          end
        end else begin
          cnt_nxt = cnt_r - RND_LAST;
        end
      end
      ST_FIN_LOAD: begin
        if (c_zero) begin
          state_nxt = d_zero ? ST_DONE : ST_FIN;
          cnt_nxt   = sts.d_rounds;
        end else begin
          state_nxt = ST_ABSORB;
          cnt_nxt   = sts.c_rounds;
          fin_nxt   = 1'b1;
        end
      end
      ST_FIN: begin
        if (last) begin
          state_nxt = ST_DONE;
        end else begin
          cnt_nxt = cnt_r - RND_LAST;
        end
      end
      ST_DONE: begin
        if (sts.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = acc;
        cmd.inject = acc && sts.full;
        cmd.xor_m  = acc && sts.full && c_zero;
      end
      ST_ABSORB: begin
        cmd.do_round = 1'b1;
        cmd.xor_m    = last;
        cmd.xor_ff   = last && fin_r;
      end
      ST_FIN_LOAD: begin
        cmd.fin_load = 1'b1;
        cmd.inject   = 1'b1;
        cmd.xor_m    = c_zero;
        cmd.xor_ff   = c_zero;
      end
      ST_FIN: begin
        cmd.do_round = 1'b1;
      end
      ST_DONE: begin
        cmd.emit = sts.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

>>> hdl/shk_datapath.sv
// ----------------------------------------------------------------------------
// shk_datapath
// key and round registers, lanes, byte packing, round unit and digest register
// ----------------------------------------------------------------------------
module shk_datapath
  import shk_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]          cfg_wdata,
  input  logic [63:0]          msg_bytes,
  input  logic [3:0]           byte_count,
  input  cmd_t                 cmd,
  input  logic                 out_ready,
  output sts_t                 sts,
  output logic                 out_valid,
  output logic [63:0]          digest
);

  logic [63:0] key_lo_r, key_hi_r;
  logic [3:0]  c_rounds_r, d_rounds_r;
  lanes_t      lanes_r, lanes_nxt;
  logic [63:0] m_r;
  logic [55:0] part_r, part_nxt;
  logic [2:0]  pcnt_r, pcnt_nxt;
  logic [7:0]  len_r, len_nxt;
  logic        open_r;
  logic        out_valid_r;
  logic [63:0] digest_r;

  logic [3:0]  n;
  logic [63:0] data;
  logic [3:0]  total;
  logic [63:0] word;
  logic [63:0] fin_word;
  logic [63:0] w_sel;
  logic [63:0] m_sel;
  lanes_t      key_init, src, rnd;
  logic        full;

  // byte packing
  assign n     = (byte_count > WORD_BYTES) ? WORD_BYTES : byte_count;
  assign data  = n[3] ? msg_bytes : (msg_bytes & ~(64'hffffffffffffffff << {n[2:0], 3'b000}));
  assign total = {1'b0, pcnt_r} + n;
  assign full  = total[3];
  assign word  = {8'h00, part_r} | (data << {pcnt_r, 3'b000});
  assign fin_word = {len_r, part_r};

  always_comb begin
    part_nxt = part_r;
    pcnt_nxt = pcnt_r;
    len_nxt  = len_r;
    if (cmd.accept) begin
      len_nxt = len_r + {4'h0, n};
      if (full) begin
        pcnt_nxt = total[2:0];
        if (pcnt_r == 3'd0) begin
          part_nxt = '0;
        end else begin
          part_nxt = 56'(data >> (7'd64 - {1'b0, pcnt_r, 3'b000}));
        end
      end else begin
        pcnt_nxt = total[2:0];
        part_nxt = word[55:0];
      end
    end
  end

  // lane update
  assign key_init.v0 = key_lo_r ^ SIP_C0;
  assign key_init.v1 = key_hi_r ^ SIP_C1;
  assign key_init.v2 = key_lo_r ^ SIP_C2;
  assign key_init.v3 = key_hi_r ^ SIP_C3;
  assign w_sel = cmd.fin_load ? fin_word : word;
  assign m_sel = cmd.inject ? w_sel : m_r;

  always_comb begin
    src = (cmd.accept && !open_r) ? key_init : lanes_r;
    rnd = cmd.do_round ? sip_round(src) : src;
    lanes_nxt.v0 = rnd.v0 ^ (cmd.xor_m ? m_sel : 64'h0);
    lanes_nxt.v1 = rnd.v1;
    lanes_nxt.v2 = rnd.v2 ^ (cmd.xor_ff ? FIN_XOR : 64'h0);
    lanes_nxt.v3 = rnd.v3 ^ (cmd.inject ? w_sel : 64'h0);
  end

  always_ff @(posedge clk) begin
    lanes_r <= lanes_nxt;
    if (cmd.inject) begin
      m_r <= w_sel;
    end
    if (cmd.emit) begin
      digest_r <= lanes_r.v0 ^ lanes_r.v1 ^ lanes_r.v2 ^ lanes_r.v3;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_lo_r    <= '0;
      key_hi_r    <= '0;
      c_rounds_r  <= RST_C_ROUNDS;
      d_rounds_r  <= RST_D_ROUNDS;
      part_r      <= '0;
      pcnt_r      <= '0;
      len_r       <= '0;
      open_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_KEY_LOW:  key_lo_r   <= cfg_wdata;
          CFG_KEY_HIGH: key_hi_r   <= cfg_wdata;
          CFG_C_ROUNDS: c_rounds_r <= cfg_wdata[3:0];
          CFG_D_ROUNDS: d_rounds_r <= cfg_wdata[3:0];
          default: begin
            key_lo_r <= key_lo_r;
          end
        endcase
      end
      if (cmd.emit) begin
        part_r      <= '0;
        pcnt_r      <= '0;
        len_r       <= '0;
        open_r      <= 1'b0;
        out_valid_r <= 1'b1;
      end else begin
        part_r <= part_nxt;
        pcnt_r <= pcnt_nxt;
        len_r  <= len_nxt;
        if (cmd.accept) begin
          open_r <= 1'b1;
        end
        if (out_ready) begin
          out_valid_r <= 1'b0;
        end
      end
    end
  end

  assign sts.full     = full;
  assign sts.c_rounds = c_rounds_r;
  assign sts.d_rounds = d_rounds_r;
  assign sts.out_free = !out_valid_r || out_ready;
  assign out_valid    = out_valid_r;
  assign digest       = digest_r;

endmodule

>>> hdl/siphash_keyed_hash_top.sv
// ----------------------------------------------------------------------------
// siphash_keyed_hash_top: keyed 64-bit hash over a byte stream, one round per cycle
// an item without a full word is only packed; one completing a word runs c rounds
// end item: final word, then c + d rounds on the shared round unit, then the digest
// synchronous active-low reset: default key 0, c = 2, d = 4, no message open
// ----------------------------------------------------------------------------
module siphash_keyed_hash_top
  import shk_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]          cfg_wdata,
  shk_in_if.sink               in_ch,
  shk_out_if.source            out_ch
);

  cmd_t cmd;
  sts_t sts;

  shk_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_end   (in_ch.end_of_message),
    .sts      (sts),
    .in_ready (in_ch.ready),
    .cmd      (cmd)
  );

  shk_datapath u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .msg_bytes  (in_ch.msg_bytes),
    .byte_count (in_ch.byte_count),
    .cmd        (cmd),
    .out_ready  (out_ch.ready),
    .sts        (sts),
    .out_valid  (out_ch.valid),
    .digest     (out_ch.digest)
  );

endmodule

>>> hdl/shk_checker.sv
// ----------------------------------------------------------------------------
// shk_checker
// port-level checks on the keyed hash top, attached by bind
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module shk_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_end,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] out_digest
);

  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_digest), "digest word dropped or changed while stalled")
  `ASSERT_NEXT(a_end_busy, clk, rst_n, in_valid && in_ready && in_end, !in_ready, "input taken right after end of message")
  `ASSERT_IMPLY(a_digest_busy, clk, rst_n, $rose(out_valid), $past(!in_ready), "digest word without finalization")
  `ASSERT_NEXT_ALWAYS(a_reset_ready, clk, !rst_n, in_ready && !out_valid, "not idle after reset")

endmodule

bind siphash_keyed_hash_top shk_checker u_shk_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .in_end     (in_ch.end_of_message),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_digest (out_ch.digest)
);
